### rtl/core/dsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_pkg
// shared widths, character codes, register indexes and the month length table
// for the date string validator
// ----------------------------------------------------------------------------
package dsv_pkg;

   localparam int CHAR_W   = 8;
   localparam int POS_W    = 4;
   localparam int DAY_W    = 7;
   localparam int MONTH_W  = 7;
   localparam int YEAR_W   = 14;
   localparam int DIGIT_W  = 4;
   localparam int MDAYS_W  = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0] DATE_LEN  = 4'd10;
   localparam logic [POS_W-1:0] POS_SAT   = 4'd11;
   localparam logic [POS_W-1:0] POS_SLASH_A = 4'd2;
   localparam logic [POS_W-1:0] POS_SLASH_B = 4'd5;
   localparam logic [POS_W-1:0] POS_MONTH   = 4'd3;
   localparam logic [POS_W-1:0] POS_YEAR    = 4'd6;
   localparam logic [POS_W-1:0] POS_CENT_LO = 4'd7;
   localparam logic [POS_W-1:0] POS_TENS    = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [YEAR_W-1:0] YEAR_LOW_RESET  = 14'd1996;
   localparam logic [YEAR_W-1:0] YEAR_HIGH_RESET = 14'd2050;

   localparam logic [CSR_IDX_W-1:0] CSR_YEAR_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YEAR_HIGH = 2'd1;

   // what the scanner knows once the final character has been folded in
   typedef struct packed {
      logic                 len_ok;
      logic                 bad_char;
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
      logic [YEAR_W-1:0]    year;
      logic                 leap;
   } scan_result_type;

   function automatic logic [MDAYS_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [MDAYS_W-1:0] days;
      case (month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                   days = 5'd30;
         7'd2:                                      days = leap ? 5'd29 : 5'd28;
         default:                                   days = 5'd0;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

### rtl/core/dsv_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsv_scan
// per-string scanner: position count, day/month/year accumulators, bad
// character flag and the digit facts needed for the leap year rule
// ----------------------------------------------------------------------------
module dsv_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [dsv_pkg::CHAR_W-1:0]    char_code,
   input  wire logic                          last_char,
   output dsv_pkg::scan_result_type           result
);

   logic [dsv_pkg::POS_W-1:0]   pos_ff,   pos_in;
   logic [dsv_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [dsv_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [dsv_pkg::YEAR_W-1:0]  year_ff,  year_in;
   logic                        bad_ff,   bad_in;
   // leap rule from decimal digits: century lsb, century mod 4, tens lsb, tens zero
   logic                        cen_lsb_ff,   cen_lsb_in;
   logic                        cen_div4_ff,  cen_div4_in;
   logic                        tens_lsb_ff,  tens_lsb_in;
   logic                        tens_zero_ff, tens_zero_in;

   logic                              is_digit;
   logic [dsv_pkg::CHAR_W-1:0]        char_off;
   logic [dsv_pkg::DIGIT_W-1:0]       digit;
   logic                              yy_zero;
   logic [1:0]                        yy_mod4;

   assign is_digit = (char_code >= dsv_pkg::CHAR_ZERO) && (char_code <= dsv_pkg::CHAR_NINE);
   assign char_off = char_code - dsv_pkg::CHAR_ZERO;
   assign digit    = char_off[dsv_pkg::DIGIT_W-1:0];

   always_comb begin
      pos_in       = pos_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      bad_in       = bad_ff;
      cen_lsb_in   = cen_lsb_ff;
      cen_div4_in  = cen_div4_ff;
      tens_lsb_in  = tens_lsb_ff;
      tens_zero_in = tens_zero_ff;

      if (pos_ff < dsv_pkg::DATE_LEN) begin
         if ((pos_ff == dsv_pkg::POS_SLASH_A) || (pos_ff == dsv_pkg::POS_SLASH_B)) begin
            if (char_code != dsv_pkg::CHAR_SLASH) begin
               bad_in = 1'b1;
            end
         end else if (is_digit) begin
            // x*10 + d as shift-and-add, wrapping at the field width
            if (pos_ff < dsv_pkg::POS_SLASH_A) begin
               day_in = (day_ff << 3) + (day_ff << 1)
                      + {{(dsv_pkg::DAY_W-dsv_pkg::DIGIT_W){1'b0}}, digit};
            end else if (pos_ff < dsv_pkg::POS_SLASH_B) begin
               month_in = (month_ff << 3) + (month_ff << 1)
                        + {{(dsv_pkg::MONTH_W-dsv_pkg::DIGIT_W){1'b0}}, digit};
            end else begin
               year_in = (year_ff << 3) + (year_ff << 1)
                       + {{(dsv_pkg::YEAR_W-dsv_pkg::DIGIT_W){1'b0}}, digit};
            end
            if (pos_ff == dsv_pkg::POS_YEAR) begin
               cen_lsb_in = digit[0];
            end
            if (pos_ff == dsv_pkg::POS_CENT_LO) begin
               cen_div4_in = (({cen_lsb_ff, 1'b0} + digit[1:0]) == 2'b00);
            end
            if (pos_ff == dsv_pkg::POS_TENS) begin
               tens_lsb_in  = digit[0];
               tens_zero_in = (digit == '0);
            end
         end else begin
            bad_in = 1'b1;
         end
      end

      if (pos_ff < dsv_pkg::POS_SAT) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // only meaningful when this character is the units digit of the year
   assign yy_zero = tens_zero_ff && (digit == '0);
   assign yy_mod4 = {tens_lsb_ff, 1'b0} + digit[1:0];

   always_comb begin
      result.len_ok   = (pos_in == dsv_pkg::DATE_LEN);
      result.bad_char = bad_in;
      result.day      = day_in;
      result.month    = month_in;
      result.year     = year_in;
      result.leap     = yy_zero ? cen_div4_ff : (yy_mod4 == 2'b00);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         pos_ff       <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         bad_ff       <= 1'b0;
         cen_lsb_ff   <= 1'b0;
         cen_div4_ff  <= 1'b0;
         tens_lsb_ff  <= 1'b0;
         tens_zero_ff <= 1'b0;
      end else if (step) begin
         pos_ff       <= pos_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         bad_ff       <= bad_in;
         cen_lsb_ff   <= cen_lsb_in;
         cen_div4_ff  <= cen_div4_in;
         tens_lsb_ff  <= tens_lsb_in;
         tens_zero_ff <= tens_zero_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/date_string_validator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_string_validator_core
// checks a DD/MM/YYYY date string streamed one character per transaction
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle with no bubbles between
// characters or between strings, save while a last character waits (below). A
// request transaction lands in an input register; from there the scanner folds
// it into the string state, and on the character marked last the full date
// check runs and its verdict goes into the response register, which drives
// rsp_valid. Characters that are not last never wait on the response side; a
// last character waits only while the previous verdict is still held by
// rsp_stall, and req_stall then follows. The year range (year_low, year_high)
// is set through the csr write port and should only be changed between strings.
// ----------------------------------------------------------------------------
module date_string_validator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel: one character per transaction
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [dsv_pkg::CHAR_W-1:0]        req_char_code,
   input  wire logic                              req_last_char,
   // response channel: one verdict per string
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_date_ok,
   // register write port
   input  wire logic                              csr_write,
   input  wire logic [dsv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dsv_pkg::YEAR_W-1:0]        csr_wdata
);

   // year range registers
   logic [dsv_pkg::YEAR_W-1:0] year_low_ff;
   logic [dsv_pkg::YEAR_W-1:0] year_high_ff;

   // input register
   logic                       in_valid_ff;
   logic [dsv_pkg::CHAR_W-1:0] in_char_ff;
   logic                       in_last_ff;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff;

   logic                       slot_free;
   logic                       step;
   logic                       take_req;
   logic                       date_ok;
   logic [dsv_pkg::MDAYS_W-1:0] mdays;

   dsv_pkg::scan_result_type   scan;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         year_low_ff  <= dsv_pkg::YEAR_LOW_RESET;
         year_high_ff <= dsv_pkg::YEAR_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dsv_pkg::CSR_YEAR_LOW:  year_low_ff  <= csr_wdata;
            dsv_pkg::CSR_YEAR_HIGH: year_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: a non-last character always moves on, a last one needs room
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_last_ff || slot_free);
   assign take_req  = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || step) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   dsv_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .result    (scan)
   );

   // full date check on the state including the final character
   assign mdays   = dsv_pkg::month_days(scan.month, scan.leap);
   assign date_ok = scan.len_ok && !scan.bad_char
                 && (scan.month >= 7'd1) && (scan.month <= 7'd12)
                 && (scan.year >= year_low_ff) && (scan.year <= year_high_ff)
                 && (scan.day >= 7'd1)
                 && (scan.day <= {{(dsv_pkg::DAY_W-dsv_pkg::MDAYS_W){1'b0}}, mdays});

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_ok_ff <= date_ok;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_date_ok = rsp_ok_ff;

   // a verdict only appears after a last character left the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("response raised without a last character");

   // the request side backs up only behind a held verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked verdict");

   // plain characters never wait
   a_plain_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_last_ff) |-> step)
      else $error("non-last character held in input register");

   // a string of the wrong length can never pass
   a_len_reject: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff && !scan.len_ok) |=> (rsp_valid_ff && !rsp_ok_ff))
      else $error("wrong-length string reported valid");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dd/mm/yyyy date string checker
// ----------------------------------------------------------------------------
// Characters are streamed one transaction at a time. A scoreboard rebuilds
// the string state on every accepted character. When a character marked last
// is accepted, it queues the verdict that the block owes for that string.
// Each response transaction is compared with the oldest queued verdict.
// A short directed table runs first. In some rows the verdict is typed in by
// hand. Random strings follow: mostly well-formed dates, mixed with damaged
// dates and pure noise. Random idling on both sides varies over three phases.
// ----------------------------------------------------------------------------
module tb;
   import dsv_pkg::*;

   // run shape
   localparam int RANDOM_CHARS_PER_PHASE = 365;
   localparam int STRINGS_PER_RANGE      = 8;
   localparam int SETTLE_CYCLES          = 4;
   localparam int DRAIN_CYCLES           = 8;
   localparam int WATCHDOG_LIMIT         = 5000;

   // csr indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // directed table markers
   localparam int RANGE_KEEP      = -1;
   localparam int VERDICT_PREDICT = -1;
   localparam int DIR_ROWS        = 26;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_char_code;
   logic                 req_last_char;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_date_ok;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [YEAR_W-1:0]    csr_wdata;

   date_string_validator_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_date_ok   (rsp_date_ok),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scoreboard copy of the year range
   logic [YEAR_W-1:0]  range_low  = YEAR_LOW_RESET;
   logic [YEAR_W-1:0]  range_high = YEAR_HIGH_RESET;

   // scoreboard copy of the string being scanned
   logic [POS_W-1:0]   scan_pos   = '0;
   logic [DAY_W-1:0]   scan_day   = '0;
   logic [MONTH_W-1:0] scan_month = '0;
   logic [YEAR_W-1:0]  scan_year  = '0;
   logic               scan_bad   = 1'b0;

   logic               pending_verdicts [$];   // verdicts owed by the block, oldest first
   int                 typed_verdicts [$];     // hand-typed verdicts of directed rows
   logic [CHAR_W-1:0]  date_chars [$];         // characters of the next string to send
   int                 verdict_errors = 0;
   int                 chars_sent = 0;
   int                 idle_cycles = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int send_idle_by_phase [3] = '{10, 79, 0};
   int rsp_stall_by_phase [3] = '{79, 10, 0};

   // years where the leap rule or the default range has an edge
   int special_years [10] = '{0, 1900, 2000, 2100, 2400, 1996, 2050, 9999, 2024, 2023};

   // directed rows: string, optional new range (low, high), verdict or predict
   string dir_text [DIR_ROWS] = '{
      "01/01/1996",      // 0  reset range, lowest year
      "31/12/2050",      // 1  reset range, highest year
      "31/12/1995",      // 2  one below the range
      "01/01/2051",      // 3  one above the range
      "29/02/2000",      // 4  leap by the 400 rule
      "29/02/1900",      // 5  century year, not leap
      "29/02/2024",      // 6
      "29/02/2023",      // 7
      "28/02/2023",      // 8
      "00/01/2000",      // 9  day zero
      "01/00/2000",      // 10 month zero
      "01/13/2000",      // 11 month thirteen
      "31/04/2000",      // 12
      "30/04/2000",      // 13
      "01/01/0000",      // 14 year zero
      "31/12/9999",      // 15 largest four digit year
      "01-01-2000",      // 16 wrong separators
      "0a/01/2000",      // 17 letter in a digit slot
      "01/01/200\377",   // 18 top character code in a digit slot
      "01/01/200",       // 19 one short
      "01/01/20000",     // 20 one long
      "01/01/2000xyz",   // 21 long enough to saturate the position
      "7",               // 22 single character
      "01/01/2000",      // 23 empty range
      "15/06/2000",      // 24 single year range
      "99/99/9999"       // 25 largest digits everywhere
   };
   int dir_low [DIR_ROWS] = '{
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, 0, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, 2001, 2000, 0
   };
   int dir_high [DIR_ROWS] = '{
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, 9999, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP,
      RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, RANGE_KEEP, 2000, 2000, 16383
   };
   int dir_verdict [DIR_ROWS] = '{
      1, 1, 0, 0, 1, 0, VERDICT_PREDICT, VERDICT_PREDICT, VERDICT_PREDICT,
      0, 0, 0, VERDICT_PREDICT, VERDICT_PREDICT, 1, 1, 0, 0, 0, 0, 0, 0, 0,
      0, 1, 0
   };

   // fold one character into the scoreboard string state; on the last
   // character hand back the verdict and start a fresh string
   task automatic fold_date_char(input logic [CHAR_W-1:0] code, input logic is_last,
                                 output logic verdict_ready, output logic verdict);
      logic [MDAYS_W-1:0] month_len;
      logic               leap;
      if (scan_pos < DATE_LEN) begin
         if (scan_pos == POS_SLASH_A || scan_pos == POS_SLASH_B) begin
            if (code != CHAR_SLASH) scan_bad = 1'b1;
         end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            if (scan_pos < POS_SLASH_A)
               scan_day = DAY_W'(scan_day * 10 + (code - CHAR_ZERO));
            else if (scan_pos < POS_SLASH_B)
               scan_month = MONTH_W'(scan_month * 10 + (code - CHAR_ZERO));
            else
               scan_year = YEAR_W'(scan_year * 10 + (code - CHAR_ZERO));
         end else begin
            scan_bad = 1'b1;
         end
      end
      if (scan_pos < POS_SAT) scan_pos = scan_pos + 1'b1;

      verdict_ready = is_last;
      verdict = 1'b0;
      if (is_last) begin
         leap = (scan_year % 400 == 0) || (scan_year % 100 != 0 && scan_year % 4 == 0);
         case (scan_month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: month_len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                   month_len = 5'd30;
            7'd2:                                      month_len = leap ? 5'd29 : 5'd28;
            default:                                   month_len = 5'd0;
         endcase
         verdict = scan_pos == DATE_LEN && !scan_bad
                && scan_month >= 1 && scan_month <= 12
                && scan_year >= range_low && scan_year <= range_high
                && scan_day >= 1 && scan_day <= month_len;
         scan_pos   = '0;
         scan_day   = '0;
         scan_month = '0;
         scan_year  = '0;
         scan_bad   = 1'b0;
      end
   endtask

   // push every queued character through the request channel; valid stays
   // high after the last one so the next string can follow without a gap
   task automatic send_date_chars();
      for (int k = 0; k < date_chars.size(); k++) begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_char_code <= date_chars[k];
         req_last_char <= (k == date_chars.size() - 1);
         do @(posedge clock); while (req_stall !== 1'b0);
         chars_sent++;
      end
   endtask

   // drop valid and wait until every owed verdict is back and the block is quiet;
   // it first lets the scoreboard queue the verdict of the last character
   task automatic wait_block_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called while the block is idle
   task automatic load_year_range(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
      // a write to an index with no register must be ignored
      csr_write <= 1'b1;
      csr_index <= ($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wdata <= YEAR_W'($urandom_range(0, 16383));
      @(posedge clock);
      csr_index <= CSR_YEAR_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      range_low = lo;
      csr_index <= CSR_YEAR_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      range_high = hi;
      csr_write <= 1'b0;
   endtask

   // response side: random stall
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // scoreboard: check the response transaction first, then predict from the
   // request transaction, so a verdict owed at this edge is never matched here
   always @(posedge clock) begin : scoreboard
      logic ready;
      logic verdict;
      logic owed;
      int   typed;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual date_ok=%0b",
                        $time, rsp_date_ok);
               verdict_errors++;
            end else begin
               owed = pending_verdicts.pop_front();
               if (rsp_date_ok !== owed) begin
                  $display("%0t: date_ok mismatch, expected %0b, actual %0b",
                           $time, owed, rsp_date_ok);
                  verdict_errors++;
               end
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            fold_date_char(req_char_code, req_last_char, ready, verdict);
            if (ready) begin
               // directed rows may carry a hand-typed verdict
               if (typed_verdicts.size() != 0) begin
                  typed = typed_verdicts.pop_front();
                  if (typed != VERDICT_PREDICT) verdict = (typed != 0);
               end
               pending_verdicts.push_back(verdict);
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d verdicts still owed",
                  $time, pending_verdicts.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                phase;
      int                phase_start;
      int                strings_in_range;
      int                roll;
      int                yr;
      int                mo;
      int                dy;
      string             txt;
      logic [YEAR_W-1:0] lo;
      logic [YEAR_W-1:0] hi;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_YEAR_LOW;
      csr_wdata     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = send_idle_by_phase[0];
      rsp_stall_pct = rsp_stall_by_phase[0];
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_low[i] != RANGE_KEEP) begin
            wait_block_idle();
            load_year_range(YEAR_W'(dir_low[i]), YEAR_W'(dir_high[i]));
         end
         typed_verdicts.push_back(dir_verdict[i]);
         date_chars.delete();
         txt = dir_text[i];
         for (int k = 0; k < txt.len(); k++) date_chars.push_back(txt[k]);
         send_date_chars();
      end

      // random strings, three idling phases
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         rsp_stall_pct = rsp_stall_by_phase[phase];
         phase_start = chars_sent;
         strings_in_range = STRINGS_PER_RANGE;
         while (chars_sent - phase_start < RANDOM_CHARS_PER_PHASE) begin
            // new year range every STRINGS_PER_RANGE strings, extremes included
            if (strings_in_range == STRINGS_PER_RANGE) begin
               wait_block_idle();
               case ($urandom_range(0, 5))
                  0: begin lo = '0; hi = YEAR_W'(9999); end
                  1: begin lo = '0; hi = '1; end
                  2: begin
                     lo = YEAR_W'($urandom_range(1900, 2100));
                     hi = lo + YEAR_W'($urandom_range(0, 150));
                  end
                  3: begin
                     lo = YEAR_W'($urandom_range(0, 16383));
                     hi = YEAR_W'($urandom_range(0, 16383));
                  end
                  4: begin lo = '1; hi = '1; end
                  default: begin
                     lo = YEAR_W'($urandom_range(0, 9999));
                     hi = lo;
                  end
               endcase
               load_year_range(lo, hi);
               strings_in_range = 0;
            end

            date_chars.delete();
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
               // well-formed shape, years biased to leap edges and range ends
               case ($urandom_range(0, 4))
                  0: yr = special_years[$urandom_range(0, 9)];
                  1: yr = int'(range_low) + int'($urandom_range(0, 2)) - 1;
                  2: yr = int'(range_high) + int'($urandom_range(0, 2)) - 1;
                  3: yr = $urandom_range(0, 9999);
                  default: yr = $urandom_range(1990, 2060);
               endcase
               if (yr < 0) yr = 0;
               if (yr > 9999) yr = 9999;
               mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
               case ($urandom_range(0, 3))
                  0: dy = $urandom_range(0, 99);
                  1: dy = $urandom_range(27, 32);
                  default: dy = $urandom_range(1, 31);
               endcase
               txt = $sformatf("%02d/%02d/%04d", dy, mo, yr);
               for (int k = 0; k < txt.len(); k++) date_chars.push_back(txt[k]);
               // damaged dates: one bad character, cut short or run long
               if (roll >= 70) begin
                  case ($urandom_range(0, 2))
                     0: date_chars[$urandom_range(0, 9)] = CHAR_W'($urandom_range(0, 255));
                     1: repeat ($urandom_range(1, 4)) void'(date_chars.pop_back());
                     default: repeat ($urandom_range(1, 4))
                        date_chars.push_back(CHAR_W'($urandom_range(0, 255)));
                  endcase
               end
            end else begin
               // noise of 1 to 14 characters with any character code
               repeat ($urandom_range(1, 14))
                  date_chars.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            send_date_chars();
            strings_in_range++;
         end
      end

      wait_block_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_errors == 0 && pending_verdicts.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
